/* design/clsup_pkg.sv */
// Shared types, codes and helpers of the crash-loop supervisor.
`timescale 1ns / 1ps
`default_nettype none
package clsup_pkg;

  // Error codes
  localparam logic [4:0] CODE_NONE      = 5'd0;
  localparam logic [4:0] CODE_WDG_RESET = 5'd11;
  localparam logic [4:0] CODE_CREDS_BLANK = 5'd15;

  localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

  // Stream widths
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_BOOT  = 2'd0,
    MODE_LOG   = 2'd1,
    MODE_CHECK = 2'd2
  } mode_e;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_UPTIME   = 2'd0,
    CFG_CRASH_LIMIT  = 2'd1,
    CFG_STREAK_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] min_uptime_ms;
    logic [7:0]  crash_limit;
    logic [14:0] streak_limit;
  } cfg_t;

  // Fields of one input item that the logic uses
  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  error_code;
    logic [31:0] tick_ms;
    logic        watchdog_caused;
    logic        rtc_ready;
  } item_t;

  typedef struct packed {
    logic        loop_tripped;
    logic [15:0] fault_streak;
    logic [15:0] crash_total;
    logic [4:0]  prior_error;
    logic [4:0]  recorded_error;
    logic [31:0] boot_count;
  } res_t;

  // Saturating increment of a retained counter
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNTER_MAX) ? COUNTER_MAX : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

/* design/clsup_cfg.sv */
// Configuration registers of the crash-loop supervisor.
`timescale 1ns / 1ps
`default_nettype none
module clsup_cfg
  import clsup_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode a register write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_UPTIME:   cfg_d.min_uptime_ms = cfg_wdata_i;
        CFG_CRASH_LIMIT:  cfg_d.crash_limit   = cfg_wdata_i[7:0];
        CFG_STREAK_LIMIT: cfg_d.streak_limit  = cfg_wdata_i[14:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_uptime_ms <= 32'd30000;
      cfg_q.crash_limit   <= 8'd5;
      cfg_q.streak_limit  <= 15'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* design/clsup_core.sv */
// Retained supervisor state and its per-item update.
`timescale 1ns / 1ps
`default_nettype none
module clsup_core
  import clsup_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output res_t       res_o
);

  // Reset cause word and app state are retained only for software readout,
  // which this block does not provide, so they are not kept here.
  logic [31:0] boots_d, boots_q;
  logic [4:0]  code_d, code_q;
  logic [31:0] tick_d, tick_q;
  logic [15:0] crash_d, crash_q;
  logic [15:0] streak_d, streak_q;

  logic [4:0]  prior;
  logic        err_boot;
  logic        short_up;
  logic        over_guard;
  logic        trip;
  logic        tripped;

  // Next state and result for the item in the input register
  always_comb begin
    boots_d  = boots_q;
    code_d   = code_q;
    tick_d   = tick_q;
    crash_d  = crash_q;
    streak_d = streak_q;
    prior    = CODE_NONE;
    tripped  = 1'b0;

    err_boot   = 1'b0;
    short_up   = (tick_q != 32'd0) && (tick_q < cfg_i.min_uptime_ms);
    over_guard = streak_q > {cfg_i.streak_limit, 1'b0};
    trip       = (crash_q >= {8'd0, cfg_i.crash_limit}) ||
                 (streak_q >= {1'b0, cfg_i.streak_limit});

    case (mode_e'(item_i.mode))
      MODE_BOOT: begin
        prior = (item_i.watchdog_caused && code_q == CODE_NONE) ? CODE_WDG_RESET
                                                                 : code_q;
        err_boot = (prior != CODE_NONE) && (prior != CODE_CREDS_BLANK);
        crash_d  = (err_boot && short_up) ? sat_inc(crash_q) : 16'd0;
        // Guard clear is overridden by the increment from zero
        streak_d = err_boot ? (over_guard ? 16'd1 : sat_inc(streak_q)) : 16'd0;
        boots_d  = boots_q + 32'd1;
        code_d   = CODE_NONE;
        tick_d   = 32'd0;
      end
      MODE_LOG: begin
        code_d = item_i.error_code;
        tick_d = item_i.tick_ms;
      end
      MODE_CHECK: begin
        if (trip && item_i.rtc_ready) begin
          tripped  = 1'b1;
          crash_d  = 16'd0;
          streak_d = 16'd0;
        end
      end
      default: begin
        boots_d = boots_q;
      end
    endcase

    res_o.boot_count     = boots_d;
    res_o.recorded_error = code_d;
    res_o.prior_error    = prior;
    res_o.crash_total    = crash_d;
    res_o.fault_streak   = streak_d;
    res_o.loop_tripped   = tripped;
  end

  // State registers advance once per transfer into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boots_q  <= 32'd0;
      code_q   <= CODE_NONE;
      tick_q   <= 32'd0;
      crash_q  <= 16'd0;
      streak_q <= 16'd0;
    end else if (step_i) begin
      boots_q  <= boots_d;
      code_q   <= code_d;
      tick_q   <= tick_d;
      crash_q  <= crash_d;
      streak_q <= streak_d;
    end
  end

`ifndef SYNTHESIS
  // A boot bumps the boot count by one
  a_boot_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.mode == MODE_BOOT) |=> boots_q == $past(boots_q) + 32'd1)
    else $error("boot count did not advance on boot");

  // Any other item leaves the boot count alone
  a_boot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.mode != MODE_BOOT) |=> $stable(boots_q))
    else $error("boot count changed on non-boot item");

  // A log item records its code
  a_log_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.mode == MODE_LOG) |=> code_q == $past(item_i.error_code))
    else $error("logged code not recorded");

  // A trip leaves both counters cleared
  a_trip_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && tripped) |=> (crash_q == 16'd0 && streak_q == 16'd0))
    else $error("counters not cleared after trip");
`endif

endmodule
`default_nettype wire

/* design/crash_loop_supervisor.sv */
// Top level of the crash-loop supervisor: stream handshake and pipeline registers.
// An input transfer is captured in the input register and its result in the output
// register when that stage can accept it; the result is then offered downstream.
// Throughput: one item per cycle unless the output stalls; the retained-state
// update is one combinational step between the input and result registers.
// Back-pressure on the output stalls the input register, which stalls tready.
// Reset (rst_ni low, asynchronous): counters and codes clear, registers take
// their default limits, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
module crash_loop_supervisor
  import clsup_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // error_code[4:0], state_word[36:5], tick_ms[68:37], reset_flags[100:69],
  // watchdog_caused[101], rtc_ready[102], zero[103]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // boot_count[31:0], recorded_error[36:32], prior_error[41:37],
  // crash_total[57:42], fault_streak[73:58], loop_tripped[74], zero[79:75]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res_d, res_q;
  logic  in_vld_q, out_vld_q;
  logic  out_adv, in_adv;

  clsup_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Handshake: each stage loads when empty or when it empties this cycle
  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign in_adv          = in_vld_q && out_adv;
  assign s_axis_tready_o = !in_vld_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (out_adv)         out_vld_q <= in_vld_q;
    end
  end

  // Input register: only the fields the logic consumes
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.mode            <= s_axis_tuser_i;
      item_q.error_code      <= s_axis_tdata_i[4:0];
      item_q.tick_ms         <= s_axis_tdata_i[68:37];
      item_q.watchdog_caused <= s_axis_tdata_i[101];
      item_q.rtc_ready       <= s_axis_tdata_i[102];
    end
  end

  clsup_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_adv),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_adv) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q};

`ifndef SYNTHESIS
  // A tripped result always reports cleared counters
  a_trip_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.loop_tripped) |->
      (res_q.crash_total == 16'd0 && res_q.fault_streak == 16'd0))
    else $error("tripped result with live counters");

  // A stalled output keeps the input stage from advancing
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !in_adv)
    else $error("input stage advanced into a stalled output");

  // A full input stage feeding a stalled output refuses new items
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("ready while both stages full and stalled");
`endif

endmodule
`default_nettype wire
